FILE: src/geba_pkg.sv
`timescale 1ns / 1ps

package geba_pkg;

  localparam int DATA_W     = 32;
  localparam int GAIN_W     = 16;
  localparam int MUL_B_W    = 18;
  localparam int PROD_W     = DATA_W + MUL_B_W;
  localparam int ACC_W      = 49;
  localparam int COUNT_W    = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int BIAS_DEPTH = 256;
  localparam int BIAS_AW    = 8;
  localparam int CDF_DEPTH  = 256;
  localparam int CDF_AW     = $clog2(CDF_DEPTH);
  localparam int CDF_W      = 17;

  localparam longint unsigned CDF_Q_DIV        = 4 * CDF_DEPTH;
  localparam longint unsigned CDF_SIMPSON_DIV  = 12 * CDF_DEPTH;
  localparam longint unsigned INV_SQRT_2PI_Q31 = 64'd856722024;

  localparam logic REQ_ELEM = 1'b0;
  localparam logic REQ_LOAD = 1'b1;

  typedef enum logic [1:0] {
    ACT_IDENT = 2'd0,
    ACT_RELU  = 2'd1,
    ACT_GELU  = 2'd2
  } act_t;

  typedef enum logic [1:0] {
    BSRC_SCALAR  = 2'd0,
    BSRC_ROW     = 2'd1,
    BSRC_COL     = 2'd2,
    BSRC_ELEMENT = 2'd3
  } bias_src_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALPHA     = 3'd0,
    REG_BETA      = 3'd1,
    REG_ACT_KIND  = 3'd2,
    REG_SKIP      = 3'd3,
    REG_BSRC_SEL  = 3'd4,
    REG_ROWS      = 3'd5,
    REG_COLS      = 3'd6
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MUL_ALPHA = 2'd0,
    MUL_BETA  = 2'd1,
    MUL_CDF   = 2'd2
  } mul_sel_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_MUL_A = 3'd1,
    ST_MUL_B = 3'd2,
    ST_SUM   = 3'd3,
    ST_LUT   = 3'd4,
    ST_GMUL  = 3'd5,
    ST_FIN   = 3'd6
  } state_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0] alpha_gain;
    logic signed [GAIN_W-1:0] beta_gain;
    act_t                     activation_kind;
    logic                     skip_activation;
    bias_src_t                bias_src;
    logic [COUNT_W-1:0]       row_count;
    logic [COUNT_W-1:0]       col_count;
  } cfg_regs_t;

  typedef struct packed {
    logic     idle;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     acc_load;
    logic     sum_load;
    logic     lut_load;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic elem_start;
    logic gelu_path;
    logic out_free;
  } dp_status_t;

  typedef logic [CDF_W-1:0] cdf_rom_t [CDF_DEPTH];

  // exp(-t*t/2)/sqrt(2pi) in q.31, taylor series at t*t/128 squared six times
  function automatic longint unsigned density_q31(input longint unsigned a);
    longint unsigned y;
    longint unsigned u;
    longint unsigned sum;
    longint unsigned term;
    longint unsigned t2;
    int n;
    int i;
    y    = (a * a) >> 25;
    u    = y << 1;
    sum  = 64'd1 << 31;
    term = 64'd1 << 31;
    for (n = 1; n <= 12; n++) begin
      t2 = (term * u) >> 31;
      case (n)
        1:       term = t2;
        2:       term = t2 / 2;
        3:       term = t2 / 3;
        4:       term = t2 / 4;
        5:       term = t2 / 5;
        6:       term = t2 / 6;
        7:       term = t2 / 7;
        8:       term = t2 / 8;
        9:       term = t2 / 9;
        10:      term = t2 / 10;
        11:      term = t2 / 11;
        default: term = t2 / 12;
      endcase
      if (n % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    for (i = 0; i < 6; i++) begin
      sum = (sum * sum) >> 31;
    end
    return (sum * INV_SQRT_2PI_Q31) >> 31;
  endfunction

  function automatic longint unsigned density_at(input longint unsigned q);
    longint unsigned num;
    longint unsigned half;
    longint unsigned a;
    num  = ((q * 64'd16) << 24) / CDF_Q_DIV;
    half = 64'd8 << 24;
    a    = (num >= half) ? num - half : half - num;
    return density_q31(a);
  endfunction

  // simpson integration of the density from -8, sampled at bin centers
  function automatic cdf_rom_t build_cdf_rom();
    cdf_rom_t        rom;
    longint unsigned acc;
    longint unsigned prev;
    longint unsigned q;
    longint unsigned mid;
    longint unsigned fin;
    longint unsigned c;
    int k;
    int h;
    acc  = 64'd0;
    q    = 64'd0;
    prev = density_at(64'd0);
    for (k = 0; k < CDF_DEPTH; k++) begin
      for (h = 0; h < 2; h++) begin
        mid  = density_at(q + 64'd1);
        fin  = density_at(q + 64'd2);
        acc  = acc + (64'd16 * (prev + 64'd4 * mid + fin)) / CDF_SIMPSON_DIV;
        prev = fin;
        q    = q + 64'd2;
        if (h == 0) begin
          c = (acc + (64'd1 << 14)) >> 15;
          if (c > 64'd65536) begin
            c = 64'd65536;
          end
          rom[k] = c[CDF_W-1:0];
        end
      end
    end
    return rom;
  endfunction

  localparam cdf_rom_t CDF_ROM = build_cdf_rom();

endpackage

FILE: src/geba_regs.sv
`timescale 1ns / 1ps

module geba_regs
  import geba_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_regs_t             cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.alpha_gain      <= 16'sd256;
      cfg.beta_gain       <= '0;
      cfg.activation_kind <= ACT_IDENT;
      cfg.skip_activation <= 1'b0;
      cfg.bias_src        <= BSRC_SCALAR;
      cfg.row_count       <= COUNT_W'(1);
      cfg.col_count       <= COUNT_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        REG_ALPHA:     cfg.alpha_gain      <= cfg_data;
        REG_BETA:      cfg.beta_gain       <= cfg_data;
        REG_ACT_KIND:  cfg.activation_kind <= act_t'(cfg_data[1:0]);
        REG_SKIP:      cfg.skip_activation <= cfg_data[0];
        REG_BSRC_SEL:  cfg.bias_src        <= bias_src_t'(cfg_data[1:0]);
        REG_ROWS:      cfg.row_count       <= cfg_data[COUNT_W-1:0];
        REG_COLS:      cfg.col_count       <= cfg_data[COUNT_W-1:0];
        default:       ;
      endcase
    end
  end

endmodule

FILE: src/geba_ctrl.sv
`timescale 1ns / 1ps

module geba_ctrl
  import geba_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (status.elem_start) state_next = ST_MUL_A;
      end
      ST_MUL_A: state_next = ST_MUL_B;
      ST_MUL_B: state_next = ST_SUM;
      ST_SUM: begin
        state_next = status.gelu_path ? ST_LUT : ST_FIN;
      end
      ST_LUT:  state_next = ST_GMUL;
      ST_GMUL: state_next = ST_FIN;
      ST_FIN: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.mul_sel = MUL_ALPHA;
    case (state)
      ST_IDLE: cmd.idle = 1'b1;
      ST_MUL_A: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_ALPHA;
      end
      ST_MUL_B: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = MUL_BETA;
        cmd.acc_load = 1'b1;
      end
      ST_SUM: cmd.sum_load = 1'b1;
      ST_LUT: cmd.lut_load = 1'b1;
      ST_GMUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_CDF;
      end
      ST_FIN: cmd.out_load = status.out_free;
      default: ;
    endcase
  end

endmodule

FILE: src/geba_dp.sv
`timescale 1ns / 1ps

module geba_dp
  import geba_pkg::*;
#(
  parameter int MAX_DIM = 256
) (
  input  logic                     clk,
  input  logic                     rst,
  input  cfg_regs_t                cfg,
  input  dp_cmd_t                  cmd,
  output dp_status_t               status,
  input  logic                     in_valid,
  input  logic                     req_type,
  input  logic signed [DATA_W-1:0] accum_value,
  input  logic signed [DATA_W-1:0] source_value,
  input  logic signed [DATA_W-1:0] element_bias,
  input  logic [BIAS_AW-1:0]       bias_slot,
  input  logic signed [DATA_W-1:0] bias_value,
  input  logic                     out_stall,
  output logic                     out_valid,
  output logic signed [DATA_W-1:0] result_value,
  output logic                     last_of_tile
);

  localparam int POS_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CW    = ($clog2(MAX_DIM + 1) > COUNT_W) ? $clog2(MAX_DIM + 1) : COUNT_W;
  localparam int KP_W  = 20 + CDF_AW + 1;
  localparam logic signed [DATA_W-1:0] GELU_LO = -(32'sd8 <<< 16);
  localparam logic signed [DATA_W-1:0] GELU_HI = 32'sd8 <<< 16;

  logic accept_elem;
  logic accept_load;

  logic [POS_W-1:0] row_pos;
  logic [POS_W-1:0] col_pos;
  logic [CW-1:0]    rows_eff;
  logic [CW-1:0]    cols_eff;
  logic [CW-1:0]    row_inc;
  logic [CW-1:0]    col_inc;
  logic             row_wrap;
  logic             col_wrap;
  logic [POS_W+BIAS_AW-1:0] row_ext;
  logic [POS_W+BIAS_AW-1:0] col_ext;
  logic [BIAS_AW-1:0]       bias_idx;

  logic signed [DATA_W-1:0] bias_mem [BIAS_DEPTH];
  logic signed [DATA_W-1:0] bias_rd;
  logic signed [DATA_W-1:0] elem_bias_q;
  logic                     bias_ext_q;
  logic signed [DATA_W-1:0] accum_q;
  logic signed [DATA_W-1:0] source_q;
  logic                     last_q;

  logic signed [DATA_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  mul_p;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   acc;
  logic signed [DATA_W-1:0]  bias_eff;
  logic signed [PROD_W-1:0]  sum;
  logic signed [41:0]        sum_sh;
  logic signed [DATA_W-1:0]  z_sat;
  logic signed [DATA_W-1:0]  z_q;

  logic [DATA_W-1:0]    off_full;
  logic [KP_W-1:0]      kprod;
  logic [CDF_AW-1:0]    kidx;
  logic [CDF_W-1:0]     cdf_q;
  logic signed [DATA_W-1:0] gelu_val;
  logic signed [DATA_W-1:0] res_next;

  assign accept_elem = in_valid && cmd.idle && (req_type == REQ_ELEM);
  assign accept_load = in_valid && cmd.idle && (req_type == REQ_LOAD);

  assign status.elem_start = accept_elem;
  assign status.gelu_path  = !cfg.skip_activation && (cfg.activation_kind == ACT_GELU);
  assign status.out_free   = !out_valid || !out_stall;

  // zero count acts as one, oversized count clamps to the maximum
  always_comb begin
    if (cfg.row_count == '0) begin
      rows_eff = CW'(1);
    end else if (CW'(cfg.row_count) > CW'(MAX_DIM)) begin
      rows_eff = CW'(MAX_DIM);
    end else begin
      rows_eff = CW'(cfg.row_count);
    end
    if (cfg.col_count == '0) begin
      cols_eff = CW'(1);
    end else if (CW'(cfg.col_count) > CW'(MAX_DIM)) begin
      cols_eff = CW'(MAX_DIM);
    end else begin
      cols_eff = CW'(cfg.col_count);
    end
  end

  assign row_inc  = CW'(row_pos) + CW'(1);
  assign col_inc  = CW'(col_pos) + CW'(1);
  assign row_wrap = row_inc >= rows_eff;
  assign col_wrap = col_inc >= cols_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_pos <= '0;
      col_pos <= '0;
    end else if (accept_elem) begin
      if (col_wrap) begin
        col_pos <= '0;
        row_pos <= row_wrap ? '0 : row_inc[POS_W-1:0];
      end else begin
        col_pos <= col_inc[POS_W-1:0];
      end
    end
  end

  // bias table index is the position modulo the table depth
  assign row_ext = {{BIAS_AW{1'b0}}, row_pos};
  assign col_ext = {{BIAS_AW{1'b0}}, col_pos};

  always_comb begin
    case (cfg.bias_src)
      BSRC_ROW: bias_idx = row_ext[BIAS_AW-1:0];
      BSRC_COL: bias_idx = col_ext[BIAS_AW-1:0];
      default:  bias_idx = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept_load) begin
      bias_mem[bias_slot] <= bias_value;
    end
    if (accept_elem) begin
      bias_rd <= bias_mem[bias_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (accept_elem) begin
      accum_q     <= accum_value;
      source_q    <= source_value;
      elem_bias_q <= element_bias;
      bias_ext_q  <= (cfg.bias_src == BSRC_ELEMENT);
      last_q      <= col_wrap && row_wrap;
    end
  end

  // shared multiplier
  always_comb begin
    case (cmd.mul_sel)
      MUL_BETA: begin
        mul_a = source_q;
        mul_b = {{(MUL_B_W-GAIN_W){cfg.beta_gain[GAIN_W-1]}}, cfg.beta_gain};
      end
      MUL_CDF: begin
        mul_a = z_q;
        mul_b = {1'b0, cdf_q};
      end
      default: begin
        mul_a = accum_q;
        mul_b = {{(MUL_B_W-GAIN_W){cfg.alpha_gain[GAIN_W-1]}}, cfg.alpha_gain};
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= mul_p;
    end
  end

  assign bias_eff = bias_ext_q ? elem_bias_q : bias_rd;

  always_ff @(posedge clk) begin
    if (cmd.acc_load) begin
      acc <= ACC_W'(prod) + (ACC_W'(bias_eff) <<< 8);
    end
  end

  // round q.24 to q16.16 and saturate
  assign sum    = PROD_W'(acc) + prod + PROD_W'(128);
  assign sum_sh = sum[PROD_W-1:8];

  always_comb begin
    if (sum_sh[41:31] == {11{1'b0}} || sum_sh[41:31] == {11{1'b1}}) begin
      z_sat = sum_sh[DATA_W-1:0];
    end else if (sum_sh[41]) begin
      z_sat = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      z_sat = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sum_load) begin
      z_q <= z_sat;
    end
  end

  // cdf bin of z over [-8, 8)
  assign off_full = z_q + 32'sd524288;
  assign kprod    = KP_W'(off_full[19:0]) * KP_W'(CDF_DEPTH);
  assign kidx     = kprod[20 +: CDF_AW];

  always_ff @(posedge clk) begin
    if (cmd.lut_load) begin
      cdf_q <= CDF_ROM[kidx];
    end
  end

  assign gelu_val = prod[16 +: DATA_W];

  always_comb begin
    res_next = z_q;
    if (!cfg.skip_activation) begin
      case (cfg.activation_kind)
        ACT_RELU: res_next = (z_q > 0) ? z_q : '0;
        ACT_GELU: begin
          if (z_q < GELU_LO) begin
            res_next = '0;
          end else if (z_q >= GELU_HI) begin
            res_next = z_q;
          end else begin
            res_next = gelu_val;
          end
        end
        default: res_next = z_q;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result_value <= res_next;
      last_of_tile <= last_q;
    end
  end

endmodule

FILE: src/gemm_epilogue_bias_activation_unit.sv
`timescale 1ns / 1ps

// gemm epilogue: z = alpha*accum + beta*source + bias, then identity, relu or gelu.
// input channel (in_valid / in_stall): req_type 0 is a tile element in row-major
//   order, req_type 1 writes bias_value into bias table slot bias_slot.
// output channel (out_valid / out_stall): one result per tile element, with
//   last_of_tile set on the element at the last row and last column.
// config channel (cfg_valid / cfg_ready): cfg_ready is always high; write only
//   while no element is in flight. indexes 0..6 select alpha, beta, activation,
//   skip, bias mode, rows, cols; index 7 is ignored.
// a bias load leaves the block idle. an element holds the input channel while
//   it passes states mul_a, mul_b, sum, (lut, gmul with gelu active) and fin:
//   the steps share one 32x18 multiplier (alpha, beta, then the cdf factor) and
//   the cdf rom lookup has a state of its own; fin loads the output register.
// a finished result waits in the output register, so the next request is
//   taken while the receiver stalls; beyond the states of that element, in_stall stays
//   high only while a second result is ready and the output register is full.
// reset clears config to defaults and the tile position to row 0, column 0; the
//   bias table is not cleared and must be loaded before it is used.
module gemm_epilogue_bias_activation_unit
  import geba_pkg::*;
#(
  parameter int MAX_DIM = 256
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     req_type,
  input  logic signed [DATA_W-1:0] accum_value,
  input  logic signed [DATA_W-1:0] source_value,
  input  logic signed [DATA_W-1:0] element_bias,
  input  logic [BIAS_AW-1:0]       bias_slot,
  input  logic signed [DATA_W-1:0] bias_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] result_value,
  output logic                     last_of_tile,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data
);

  cfg_regs_t  cfg;
  dp_cmd_t    cmd;
  dp_status_t status;

  assign in_stall = !cmd.idle;

  geba_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  geba_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  geba_dp #(
    .MAX_DIM (MAX_DIM)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cmd          (cmd),
    .status       (status),
    .in_valid     (in_valid),
    .req_type     (req_type),
    .accum_value  (accum_value),
    .source_value (source_value),
    .element_bias (element_bias),
    .bias_slot    (bias_slot),
    .bias_value   (bias_value),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .result_value (result_value),
    .last_of_tile (last_of_tile)
  );

endmodule

FILE: src/geba_chk.sv
`timescale 1ns / 1ps

module geba_chk
  import geba_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic                     req_type,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic signed [DATA_W-1:0] result_value,
  input logic                     last_of_tile
);

  // a waiting result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(result_value) && $stable(last_of_tile))
    else $error("stalled result changed");

  // an element request keeps the block busy on the next cycle
  a_elem_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && req_type == REQ_ELEM |=> in_stall)
    else $error("element request did not occupy the block");

  // a bias load never produces a result
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && req_type == REQ_LOAD && !out_valid |=> !out_valid)
    else $error("bias load produced a result");

  // a new result only appears after the block was busy
  a_out_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without work in flight");

endmodule

bind gemm_epilogue_bias_activation_unit geba_chk u_chk (.*);
